FILE: rtl/ipv6p_pkg.sv
// Shared types, constants and the hex digit decoder of the IPv6 text parser.
`timescale 1ns / 1ps

package ipv6p_pkg;

	localparam int GROUPS     = 8;
	localparam int MAX_DIGITS = 4;
	localparam int ADDR_W     = 128;

	localparam logic [7:0] NO_HEX = 8'hff;
	localparam logic [7:0] COLON  = 8'h3a;

	// Scan phases
	localparam logic [2:0] PH_START      = 3'd0;
	localparam logic [2:0] PH_LEAD_COLON = 3'd1;
	localparam logic [2:0] PH_IN_GROUP   = 3'd2;
	localparam logic [2:0] PH_AFTER_SEP  = 3'd3;
	localparam logic [2:0] PH_AFTER_GAP  = 3'd4;

	// Scanner state seen by the result assembly
	typedef struct packed {
		logic [ADDR_W-1:0] groups;   // completed groups, newest in the low 16 bits
		logic [3:0]        count;
		logic              gap_seen;
		logic [2:0]        gap_pos;
		logic [15:0]       cur;
		logic [2:0]        phase;
		logic              fault;
	} scan_state_t;

	// ASCII hex digit to value, NO_HEX otherwise
	function automatic logic [7:0] hex_digit(input logic [7:0] ch);
		logic [7:0] v;
		v = NO_HEX;
		case (ch) inside
			[8'h30:8'h39]: v = ch - 8'h30;
			[8'h61:8'h66]: v = ch - 8'h57;
			[8'h41:8'h46]: v = ch - 8'h37;
			default:       v = NO_HEX;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/ipv6p_scan.sv
// Character scanner: group, separator and gap tracking for the IPv6 text parser.
`timescale 1ns / 1ps

module ipv6p_scan (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           character,
	input  logic                 end_of_text,
	output ipv6p_pkg::scan_state_t state
);

	logic [127:0] groups_q, groups_d;
	logic [3:0]   count_q, count_d;
	logic         gap_q, gap_d;
	logic [2:0]   gap_pos_q, gap_pos_d;
	logic [15:0]  cur_q, cur_d;
	logic [2:0]   digits_q, digits_d;
	logic [2:0]   phase_q, phase_d;
	logic         fault_q, fault_d;

	logic [7:0]   hex_v;
	logic         colon;

	assign hex_v = ipv6p_pkg::hex_digit(character);
	assign colon = (character == ipv6p_pkg::COLON);

	// Next state for one character
	always_comb begin
		groups_d  = groups_q;
		count_d   = count_q;
		gap_d     = gap_q;
		gap_pos_d = gap_pos_q;
		cur_d     = cur_q;
		digits_d  = digits_q;
		phase_d   = phase_q;
		fault_d   = fault_q;
		if (!fault_q) begin
			if (hex_v == ipv6p_pkg::NO_HEX && !colon) begin
				fault_d = 1'b1;
			end else begin
				case (phase_q)
					ipv6p_pkg::PH_START: begin
						if (colon) begin
							phase_d = ipv6p_pkg::PH_LEAD_COLON;
						end else begin
							cur_d    = {12'd0, hex_v[3:0]};
							digits_d = 3'd1;
							phase_d  = ipv6p_pkg::PH_IN_GROUP;
						end
					end
					ipv6p_pkg::PH_LEAD_COLON, ipv6p_pkg::PH_AFTER_SEP: begin
						if (colon) begin
							// second colon of a gap
							if (gap_q || count_q >= 4'(ipv6p_pkg::GROUPS - 1)) begin
								fault_d = 1'b1;
							end else begin
								gap_d     = 1'b1;
								gap_pos_d = count_q[2:0];
								phase_d   = ipv6p_pkg::PH_AFTER_GAP;
							end
						end else if (phase_q == ipv6p_pkg::PH_LEAD_COLON) begin
							fault_d = 1'b1;
						end else begin
							cur_d    = {12'd0, hex_v[3:0]};
							digits_d = 3'd1;
							phase_d  = ipv6p_pkg::PH_IN_GROUP;
						end
					end
					ipv6p_pkg::PH_IN_GROUP: begin
						if (colon) begin
							// close the group
							phase_d = ipv6p_pkg::PH_AFTER_SEP;
							if (count_q >= 4'(ipv6p_pkg::GROUPS)) begin
								fault_d = 1'b1;
							end else begin
								groups_d = {groups_q[111:0], cur_q};
								count_d  = count_q + 4'd1;
								cur_d    = 16'd0;
								digits_d = 3'd0;
							end
						end else if (digits_q >= 3'(ipv6p_pkg::MAX_DIGITS)) begin
							fault_d = 1'b1;
						end else begin
							cur_d    = {cur_q[11:0], hex_v[3:0]};
							digits_d = digits_q + 3'd1;
						end
					end
					ipv6p_pkg::PH_AFTER_GAP: begin
						if (colon) begin
							fault_d = 1'b1;
						end else begin
							cur_d    = {12'd0, hex_v[3:0]};
							digits_d = 3'd1;
							phase_d  = ipv6p_pkg::PH_IN_GROUP;
						end
					end
					default: fault_d = 1'b1;
				endcase
			end
		end
	end

	// Group shift line, no reset needed
	always_ff @(posedge clk) begin
		if (step && !end_of_text) begin
			groups_q <= groups_d;
		end
	end

	// Control state; the end of a text starts a fresh one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= 4'd0;
			gap_q     <= 1'b0;
			gap_pos_q <= 3'd0;
			cur_q     <= 16'd0;
			digits_q  <= 3'd0;
			phase_q   <= ipv6p_pkg::PH_START;
			fault_q   <= 1'b0;
		end else if (step) begin
			if (end_of_text) begin
				count_q   <= 4'd0;
				gap_q     <= 1'b0;
				gap_pos_q <= 3'd0;
				cur_q     <= 16'd0;
				digits_q  <= 3'd0;
				phase_q   <= ipv6p_pkg::PH_START;
				fault_q   <= 1'b0;
			end else begin
				count_q   <= count_d;
				gap_q     <= gap_d;
				gap_pos_q <= gap_pos_d;
				cur_q     <= cur_d;
				digits_q  <= digits_d;
				phase_q   <= phase_d;
				fault_q   <= fault_d;
			end
		end
	end

	assign state.groups   = groups_q;
	assign state.count    = count_q;
	assign state.gap_seen = gap_q;
	assign state.gap_pos  = gap_pos_q;
	assign state.cur      = cur_q;
	assign state.phase    = phase_q;
	assign state.fault    = fault_q;

endmodule

FILE: rtl/ipv6p_assemble.sv
// End-of-text check and zero-gap expansion into the 128-bit address.
`timescale 1ns / 1ps

module ipv6p_assemble (
	input  ipv6p_pkg::scan_state_t state,
	output logic                   ok,
	output logic [127:0]           address
);

	logic         commit;
	logic         fault_f;
	logic [127:0] groups_f;
	logic [3:0]   count_f;
	logic [3:0]   fill;
	logic [3:0]   tail;
	logic [127:0] shifted;
	logic [127:0] merged;

	// Close a group still open at the end
	always_comb begin
		commit   = !state.fault && (state.phase == ipv6p_pkg::PH_IN_GROUP);
		fault_f  = state.fault;
		groups_f = state.groups;
		count_f  = state.count;
		if (commit) begin
			if (state.count >= 4'(ipv6p_pkg::GROUPS)) begin
				fault_f = 1'b1;
			end else begin
				groups_f = {state.groups[111:0], state.cur};
				count_f  = state.count + 4'd1;
			end
		end
	end

	// Validity of the whole text
	always_comb begin
		ok = !fault_f && (state.phase == ipv6p_pkg::PH_IN_GROUP ||
			state.phase == ipv6p_pkg::PH_AFTER_GAP);
		if (state.gap_seen) begin
			ok = ok && (count_f < 4'(ipv6p_pkg::GROUPS));
		end else begin
			ok = ok && (count_f == 4'(ipv6p_pkg::GROUPS));
		end
	end

	// Head groups move to the top, tail groups stay low, zeros between
	assign fill    = 4'(ipv6p_pkg::GROUPS) - count_f;
	assign tail    = count_f - {1'b0, state.gap_pos};
	assign shifted = groups_f << {fill, 4'b0000};

	always_comb begin
		for (int i = 0; i < ipv6p_pkg::GROUPS; i++) begin
			// lane i counts from the top group
			if (!state.gap_seen) begin
				merged[127-16*i -: 16] = groups_f[127-16*i -: 16];
			end else if (4'(i) < {1'b0, state.gap_pos}) begin
				merged[127-16*i -: 16] = shifted[127-16*i -: 16];
			end else if (4'(i) >= 4'(ipv6p_pkg::GROUPS) - tail) begin
				merged[127-16*i -: 16] = groups_f[127-16*i -: 16];
			end else begin
				merged[127-16*i -: 16] = 16'd0;
			end
		end
	end

	assign address = ok ? merged : 128'd0;

endmodule

FILE: rtl/ipv6_text_address_parser_unit.sv
// Top level of the IPv6 text address parser: input stage, scanner, result register.
`timescale 1ns / 1ps

// IPv6 address text parser.
// Input channel (in_valid/in_ready): one ASCII character per transfer, or a
// transfer with end_of_text high that closes the text (its character is ignored).
// Output channel (out_valid/out_ready): one result per end transfer, carrying
// address_valid and the address as address_high (groups 0-3) and
// address_low (groups 4-7); both halves read zero when the text is malformed.
// Throughput: one transfer per cycle while in_ready is high. Every transfer
// lands in an input register; the scanner updates from that register, and
// the result of an end transfer is loaded into the output register as the
// scanner takes it, which raises out_valid.
// Characters keep flowing while a result waits. An end transfer held in the
// input register waits only if the output register is still full and
// out_ready is low; in_ready then drops until the result is taken.
// Reset (arst_n low) empties both registers and puts the scanner at the start
// of a new text; each end transfer does the same for the scanner.
module ipv6_text_address_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  character,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        address_valid,
	output logic [63:0] address_high,
	output logic [63:0] address_low
);

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        end_s1;
	logic        advance;

	ipv6p_pkg::scan_state_t state;
	logic                   ok;
	logic [127:0]           address;

	logic        out_valid_q;
	logic        ok_q;
	logic [127:0] address_q;

	// Stage 1 moves on unless an end transfer meets a full, stalled output
	assign advance  = valid_s1 && (!end_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= character;
			end_s1  <= end_of_text;
		end
	end

	ipv6p_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.character   (char_s1),
		.end_of_text (end_s1),
		.state       (state)
	);

	ipv6p_assemble u_assemble (
		.state   (state),
		.ok      (ok),
		.address (address)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && end_s1) begin
			ok_q      <= ok;
			address_q <= address;
		end
	end

	assign out_valid     = out_valid_q;
	assign address_valid = ok_q;
	assign address_high  = address_q[127:64];
	assign address_low   = address_q[63:0];

endmodule
